// ----- rtl/stfl_pkg.sv -----
// Shared types, codes and sizes for the sorted table floor lookup block.
package stfl_pkg;

	// Table size and the widths that follow from it.
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PRB_W = CNT_W + 1;

	// Field widths and stream packing.
	localparam int KEY_W = 16;
	localparam int LINE_W = 16;
	localparam int OFF_W = 17;
	localparam int RES_W = 17;
	localparam int ENTRY_W = KEY_W + LINE_W;
	localparam int IN_DATA_W = ((KEY_W + LINE_W + OFF_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
	localparam int OP_W = 2;
	localparam int STATUS_W = 3;

	// Operation codes carried in the input tuser.
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Result status codes carried in the output tuser.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_PASS   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BEFORE = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	// Source of a result loaded into the result register.
	typedef enum logic [2:0] {
		RES_ZERO_OK,
		RES_FULL,
		RES_PASS,
		RES_EMPTY,
		RES_BEFORE,
		RES_RAM,
		RES_HELD
	} res_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_ADDR,
		S_SRCH_CMP,
		S_SCAN_ADDR,
		S_SCAN_CMP,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear;
		logic append;
		logic init;
		logic probe_rd;
		logic halve;
		logic take;
		logic scan_init;
		logic scan_rd;
		logic scan_adv;
		logic res_en;
		res_t res_sel;
		logic push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic off_nonpos;
		logic half_zero;
		logic probe_out;
		logic idx_end;
		logic gt;
		logic eq;
		logic lt;
		logic have;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/sorted_table_floor_lookup.sv -----
// Top level of the sorted table floor lookup: controller, datapath and stream ports.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tuser: operation; tdata: start, line, offset
//  m_*      out        m_tvalid/m_tready  tuser: status; tdata: line_value
//
// Clear, append and queries answered without a search go from S_IDLE through S_DECODE to S_DONE,
// which moves the result into the output register once that register is free.
// A searching query probes in S_SRCH_ADDR and S_SRCH_CMP until a hit or a zero step (a probe past
// the end only halves the step), then scans forward in S_SCAN_ADDR and S_SCAN_CMP to a start above
// the key, a hit or the end of the table; a full sorted 256-entry table needs at most 8 probes
// and 1 to 2 scan compares; each waits on the registered read of the table RAM, one probe at a time.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Reset clears the entry count, the controller and the output valid; the table is not cleared.
module sorted_table_floor_lookup
	import stfl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // entry_start[15:0], entry_line[31:16], query_offset[48:32]
	input  logic [OP_W-1:0]       s_tuser,  // operation[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // line_value[16:0]
	output logic [STATUS_W-1:0]   m_tuser   // status[2:0]
);
	cmd_t              cmd;
	stat_t             st;
	logic [RES_W-1:0]  line_value;

	stfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	stfl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_start  (s_tdata[KEY_W-1:0]),
		.in_line   (s_tdata[KEY_W+LINE_W-1:KEY_W]),
		.in_offset (s_tdata[KEY_W+LINE_W+OFF_W-1:KEY_W+LINE_W]),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_line  (line_value),
		.out_status(m_tuser)
	);

	// Pad the result to whole bytes.
	assign m_tdata = OUT_DATA_W'(line_value);

endmodule

// ----- rtl/stfl_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module stfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/stfl_ctrl.sv -----
// Controller state machine that sequences clear, append and the table search.
module stfl_ctrl
	import stfl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (st.op == OP_QUERY && !st.off_nonpos && !st.empty) begin
					state_d = S_SRCH_ADDR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRCH_ADDR: begin
				if (st.half_zero) begin
					state_d = S_SCAN_ADDR;
				end else if (!st.probe_out) begin
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				state_d = st.eq ? S_DONE : S_SRCH_ADDR;
			end
			S_SCAN_ADDR: begin
				state_d = st.idx_end ? S_DONE : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = (st.lt || st.eq) ? S_DONE : S_SCAN_ADDR;
			end
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd = '0;
		cmd.res_sel = RES_ZERO_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				unique case (st.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						cmd.res_en = 1'b1;
					end
					OP_APPEND: begin
						cmd.append = !st.full;
						cmd.res_en = 1'b1;
						cmd.res_sel = st.full ? RES_FULL : RES_ZERO_OK;
					end
					OP_QUERY: begin
						if (st.off_nonpos) begin
							cmd.res_en = 1'b1;
							cmd.res_sel = RES_PASS;
						end else if (st.empty) begin
							cmd.res_en = 1'b1;
							cmd.res_sel = RES_EMPTY;
						end else begin
							cmd.init = 1'b1;
						end
					end
					default: begin
						cmd.res_en = 1'b1;
					end
				endcase
			end
			S_SRCH_ADDR: begin
				if (st.half_zero) begin
					cmd.scan_init = 1'b1;
				end else if (st.probe_out) begin
					cmd.halve = 1'b1;
				end else begin
					cmd.probe_rd = 1'b1;
				end
			end
			S_SRCH_CMP: begin
				if (st.eq) begin
					cmd.res_en = 1'b1;
					cmd.res_sel = RES_RAM;
				end else begin
					cmd.take = 1'b1;
					cmd.halve = 1'b1;
				end
			end
			S_SCAN_ADDR: begin
				if (st.idx_end) begin
					cmd.res_en = 1'b1;
					cmd.res_sel = st.have ? RES_HELD : RES_BEFORE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_SCAN_CMP: begin
				if (st.lt) begin
					cmd.res_en = 1'b1;
					cmd.res_sel = st.have ? RES_HELD : RES_BEFORE;
				end else if (st.eq) begin
					cmd.res_en = 1'b1;
					cmd.res_sel = RES_RAM;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			S_DONE: begin
				cmd.push = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/stfl_dp.sv -----
// Datapath: item capture, entry count, search registers, table RAM and output register.
module stfl_dp
	import stfl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [OP_W-1:0]      in_op,
	input  logic [KEY_W-1:0]     in_start,
	input  logic [LINE_W-1:0]    in_line,
	input  logic [OFF_W-1:0]     in_offset,
	input  cmd_t                 cmd,
	output stat_t                st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RES_W-1:0]     out_line,
	output logic [STATUS_W-1:0]  out_status
);
	// Captured item.
	op_t               op_q;
	logic [KEY_W-1:0]  start_q;
	logic [LINE_W-1:0] line_in_q;
	logic [OFF_W-1:0]  off_q;

	// Table and search state.
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  base_q;
	logic [CNT_W-1:0]  half_q;
	logic [CNT_W-1:0]  idx_q;
	logic              have_q;
	logic [LINE_W-1:0] held_line_q;
	logic [PRB_W-1:0]  probe;

	// Result and output registers.
	logic [RES_W-1:0]    res_line_q;
	status_t             res_status_q;
	logic                out_valid_q;
	logic [RES_W-1:0]    out_line_q;
	logic [STATUS_W-1:0] out_status_q;

	// RAM port signals.
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [KEY_W-1:0]   ram_start;
	logic [LINE_W-1:0]  ram_line;
	logic [KEY_W-1:0]   key;

	assign probe = {1'b0, base_q} + {1'b0, half_q};
	assign ram_start = ram_rdata[KEY_W-1:0];
	assign ram_line = ram_rdata[ENTRY_W-1:KEY_W];
	// The offset is known positive once a search runs, so its low bits are the key.
	assign key = off_q[KEY_W-1:0];

	// Table RAM, one entry holds start and line.
	assign ram_re = cmd.probe_rd | cmd.scan_rd;
	assign ram_raddr = cmd.probe_rd ? probe[IDX_W-1:0] : idx_q[IDX_W-1:0];

	stfl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({line_in_q, start_q}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(in_op);
			start_q <= in_start;
			line_in_q <= in_line;
			off_q <= in_offset;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Binary search and forward scan registers.
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			base_q <= '0;
			half_q <= count_q >> 1;
		end else begin
			if (cmd.take && st.gt) base_q <= probe[CNT_W-1:0];
			if (cmd.halve) half_q <= half_q >> 1;
		end
		if (cmd.scan_init) begin
			idx_q <= base_q;
		end else if (cmd.scan_adv) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.init) begin
			have_q <= 1'b0;
		end else if (cmd.scan_adv) begin
			have_q <= 1'b1;
			held_line_q <= ram_line;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			case (cmd.res_sel)
				RES_FULL: begin
					res_line_q <= '0;
					res_status_q <= ST_FULL;
				end
				RES_PASS: begin
					res_line_q <= off_q;
					res_status_q <= ST_PASS;
				end
				RES_EMPTY: begin
					res_line_q <= '0;
					res_status_q <= ST_EMPTY;
				end
				RES_BEFORE: begin
					res_line_q <= '0;
					res_status_q <= ST_BEFORE;
				end
				RES_RAM: begin
					res_line_q <= RES_W'(ram_line);
					res_status_q <= ST_OK;
				end
				RES_HELD: begin
					res_line_q <= RES_W'(held_line_q);
					res_status_q <= ST_OK;
				end
				default: begin
					res_line_q <= '0;
					res_status_q <= ST_OK;
				end
			endcase
		end
	end

	// Output register: holds a finished item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_line_q <= res_line_q;
			out_status_q <= res_status_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		st.op = op_q;
		st.full = (count_q == CNT_W'(TABLE_DEPTH));
		st.empty = (count_q == '0);
		st.off_nonpos = off_q[OFF_W-1] || (off_q == '0);
		st.half_zero = (half_q == '0);
		st.probe_out = (probe >= {1'b0, count_q});
		st.idx_end = (idx_q >= count_q);
		st.gt = (key > ram_start);
		st.eq = (key == ram_start);
		st.lt = (key < ram_start);
		st.have = have_q;
		st.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_line = out_line_q;
	assign out_status = out_status_q;

endmodule

// ----- rtl/stfl_chk.sv -----
// Port checker for the sorted table floor lookup, bound to the top level.
module stfl_chk
	import stfl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [OP_W-1:0]       s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]   m_tuser
);
	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Only found and pass-through results carry a nonzero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK && m_tuser != ST_PASS |-> m_tdata[RES_W-1:0] == '0)
		else $error("nonzero value with a non-data status");

	// A pass-through value is zero or negative.
	a_pass_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_PASS |-> m_tdata[RES_W-1] || m_tdata[RES_W-1:0] == '0)
		else $error("pass-through of a positive offset");

	// One item at a time: after an accepted item the input is not ready and no new result rises.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
		else $error("input ready or result right after an accepted item");

endmodule

bind sorted_table_floor_lookup stfl_chk u_stfl_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ----- test/sorted_table_floor_lookup_tb.sv -----
// Self-checking stream testbench for the sorted table floor lookup block.
`timescale 1ns / 100ps

module sorted_table_floor_lookup_tb;
	import stfl_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	// One input item, with the idle cycles the sender leaves after it.
	typedef struct {
		op_t                      op;
		logic [KEY_W-1:0]         start;
		logic [LINE_W-1:0]        line;
		logic signed [OFF_W-1:0]  offset;
		int unsigned              gap_after;
	} lookup_item_t;

	// One result item.
	typedef struct {
		logic signed [RES_W-1:0] line_value;
		status_t                 status;
	} lookup_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	wire signed [RES_W-1:0] got_line = m_tdata[RES_W-1:0];

	// Items waiting to be sent and results waiting to arrive.
	lookup_item_t   queued_items[$];
	lookup_result_t due_results[$];
	lookup_item_t   cur_item;
	lookup_result_t due_head;
	int unsigned    wait_left = 0;
	int unsigned    stall_left = 0;
	bit             ready_steady = 1'b0;
	int             error_count = 0;
	int             idle_cycles = 0;
	int             gen_count = 0;

	// Predicted table contents and the starts the generator has loaded.
	logic [KEY_W-1:0]  start_tbl[TABLE_DEPTH];
	logic [LINE_W-1:0] line_tbl[TABLE_DEPTH];
	int                entry_total = 0;
	logic [KEY_W-1:0]  gen_starts[$];

	sorted_table_floor_lookup uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one item to the predicted table and returns the line it resolves to.
	// A query runs a binary search for a first index and then scans forward.
	function automatic lookup_result_t predict_line(lookup_item_t it);
		lookup_result_t r;
		int off, half, base, p, s, i, line;
		bit have;
		r.line_value = '0;
		r.status = ST_OK;
		case (it.op)
		OP_CLEAR: begin
			entry_total = 0;
		end
		OP_APPEND: begin
			if (entry_total >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				start_tbl[entry_total] = it.start;
				line_tbl[entry_total] = it.line;
				entry_total++;
			end
		end
		OP_QUERY: begin
			off = it.offset;
			if (off <= 0) begin
				r.line_value = it.offset;
				r.status = ST_PASS;
				return r;
			end
			if (entry_total == 0) begin
				r.status = ST_EMPTY;
				return r;
			end
			base = 0;
			half = entry_total >> 1;
			while (half > 0) begin
				p = base + half;
				if (p < entry_total) begin
					s = start_tbl[p];
					if (off > s) begin
						base = p;
					end else if (off == s) begin
						r.line_value = RES_W'(line_tbl[p]);
						return r;
					end
				end
				half = half >> 1;
			end
			have = 1'b0;
			line = 0;
			for (i = base; i < entry_total; i++) begin
				s = start_tbl[i];
				if (off < s)
					break;
				if (off == s) begin
					r.line_value = RES_W'(line_tbl[i]);
					return r;
				end
				line = line_tbl[i];
				have = 1'b1;
			end
			if (have)
				r.line_value = RES_W'(line);
			else
				r.status = ST_BEFORE;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	// Queues one item; steady items leave no gap behind them.
	task automatic push_item(op_t op, int start, int line, int offset, bit steady);
		lookup_item_t it;
		it.op = op;
		it.start = KEY_W'(start);
		it.line = LINE_W'(line);
		it.offset = OFF_W'(offset);
		it.gap_after = steady ? 0 : pick_gap();
		queued_items.push_back(it);
		gen_count++;
		if (op == OP_CLEAR)
			gen_starts.delete();
		else if (op == OP_APPEND && gen_starts.size() < TABLE_DEPTH)
			gen_starts.push_back(KEY_W'(start));
	endtask

	// Rebuilds the table with n strictly increasing starts and random lines.
	task automatic push_sorted(int n, bit steady);
		int span, cur, j;
		span = $urandom_range(1, 65535 / n);
		cur = $urandom_range(0, span);
		push_item(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 131071), steady);
		for (j = 0; j < n; j++) begin
			push_item(OP_APPEND, cur, $urandom_range(0, 65535), $urandom_range(0, 131071),
				steady);
			cur = cur + $urandom_range(1, span);
		end
	endtask

	// Queries aimed at the loaded starts: exact hits, between entries, below the
	// first, past the last, pass-through values and the offset extremes.
	task automatic push_queries(int k, bit steady);
		int j, pick, q, cnt;
		for (j = 0; j < k; j++) begin
			cnt = gen_starts.size();
			pick = $urandom_range(0, 9);
			q = $urandom_range(0, 131071) - 65536;
			if (cnt != 0) begin
				case (pick)
				0, 1, 2: q = gen_starts[$urandom_range(0, cnt - 1)];
				3, 4: q = gen_starts[$urandom_range(0, cnt - 1)] + $urandom_range(1, 300);
				5: q = gen_starts[0] - $urandom_range(1, 50);
				6: q = gen_starts[cnt - 1] + $urandom_range(1, 5000);
				default: begin
				end
				endcase
			end
			if (pick == 7)
				q = -$urandom_range(0, 65536);
			if (pick == 8)
				q = ($urandom_range(0, 1) != 0) ? 65535 : -65536;
			if (q > 65535)
				q = 65535;
			push_item(OP_QUERY, $urandom_range(0, 65535), $urandom_range(0, 65535), q, steady);
		end
	endtask

	// Holds until every queued item is taken and every result is back.
	task automatic drain_results();
		while (queued_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Sender: predicts each accepted item and presents the next after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_CLEAR;
			wait_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				due_results.push_back(predict_line(cur_item));
			if (!s_tvalid || s_tready) begin
				if (wait_left != 0) begin
					wait_left <= wait_left - 1;
					s_tvalid <= 1'b0;
				end else if (queued_items.size() != 0) begin
					cur_item = queued_items.pop_front();
					s_tdata <= IN_DATA_W'({cur_item.offset, cur_item.line, cur_item.start});
					s_tuser <= cur_item.op;
					s_tvalid <= 1'b1;
					wait_left <= cur_item.gap_after;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result against the oldest prediction, stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result with none expected: line_value %0d status %0d",
						got_line, m_tuser);
					error_count = error_count + 1;
				end else begin
					due_head = due_results.pop_front();
					if (got_line !== due_head.line_value) begin
						$error("line_value: expected %0d, got %0d", due_head.line_value, got_line);
						error_count = error_count + 1;
					end
					if (m_tuser !== due_head.status) begin
						$error("status: expected %0d, got %0d", due_head.status, m_tuser);
						error_count = error_count + 1;
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				ready_steady <= !ready_steady;
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!ready_steady && $urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[sorted_table_floor_lookup] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int r, n, j;
		bit steady;
		bit full_done;
		full_done = 1'b0;

		// Empty table, pass-through offsets and the unused operation.
		push_item(OP_QUERY, 0, 0, 5, 1'b0);
		push_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 0, 1'b0);
		push_item(OP_QUERY, 0, 0, -65536, 1'b0);
		push_item(OP_QUERY, 0, 0, -1, 1'b0);
		push_item(OP_NONE, 16'hFFFF, 16'hFFFF, -1, 1'b0);

		// Starts and lines at their extremes, then floor and exact hits.
		push_item(OP_APPEND, 0, 16'h1234, 0, 1'b0);
		push_item(OP_APPEND, 16'h0100, 16'hFFFF, 0, 1'b0);
		push_item(OP_APPEND, 16'h8000, 0, 0, 1'b0);
		push_item(OP_APPEND, 16'hFFFF, 16'h5555, 0, 1'b0);
		push_item(OP_QUERY, 0, 0, 1, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h0100, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h7FFF, 1'b0);
		push_item(OP_QUERY, 0, 0, 65535, 1'b0);

		// An offset below the only start, then its exact and far matches.
		push_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 65535, 1'b0);
		push_item(OP_APPEND, 16'h0200, 7, 0, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h01FF, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h0200, 1'b0);
		push_item(OP_QUERY, 0, 0, 65535, 1'b0);

		// A table loaded out of order.
		push_item(OP_CLEAR, 0, 0, 0, 1'b0);
		push_item(OP_APPEND, 16'h0300, 1, 0, 1'b0);
		push_item(OP_APPEND, 16'h0100, 2, 0, 1'b0);
		push_item(OP_APPEND, 16'h0200, 3, 0, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h0250, 1'b0);
		push_item(OP_QUERY, 0, 0, 16'h0150, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The generator holds off here until the block has answered everything.
		drain_results();

		gen_count = 0;
		while (gen_count < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (!full_done && gen_count > 200) begin
				// Fill the table to the brim, then push past it.
				push_sorted(TABLE_DEPTH, steady);
				for (j = 0; j < 3; j++)
					push_item(OP_APPEND, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 131071), steady);
				push_queries(20, steady);
				full_done = 1'b1;
			end else if (r < 65) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
				push_sorted(n, steady);
				push_queries($urandom_range(4, 10), steady);
			end else if (r < 80) begin
				// Unsorted starts, possibly repeated.
				push_item(OP_CLEAR, 0, 0, 0, steady);
				n = $urandom_range(1, 10);
				for (j = 0; j < n; j++)
					push_item(OP_APPEND, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 131071), steady);
				push_queries($urandom_range(3, 8), steady);
			end else begin
				// Noise: any operation with any field values.
				n = $urandom_range(3, 8);
				for (j = 0; j < n; j++)
					push_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 131071), steady);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[sorted_table_floor_lookup] OK");
		else
			$display("[sorted_table_floor_lookup] ERROR");
		$finish;
	end

endmodule
